// ===== design/sdspi_pkg.sv =====
// shared constants and crc helper for the sd card spi command sequencer
package sdspi_pkg;

  localparam logic [3:0] IDLE_CLOCK_BYTES = 4'd10;

  localparam logic [1:0] ACT_EXCHANGE = 2'd0;
  localparam logic [1:0] ACT_INIT     = 2'd1;
  localparam logic [1:0] ACT_OPEN     = 2'd2;
  localparam logic [1:0] ACT_CLOSE    = 2'd3;

  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_SEND_IF    = 6'd8;
  localparam logic [5:0] CMD_STOP_TRANS = 6'd12;
  localparam logic [5:0] CMD_READ_MULTI = 6'd18;
  localparam logic [5:0] CMD_SD_OP_COND = 6'd41;
  localparam logic [5:0] CMD_APP_CMD    = 6'd55;

  localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
  localparam logic [39:0] R7_EXPECTED = 40'h01_0000_01AA;

  localparam logic [7:0] CMD_START_BITS = 8'h40;
  localparam logic [7:0] BYTE_IDLE      = 8'hFF;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [7:0] R1_IDLE_STATE  = 8'h01;
  localparam logic [7:0] DATA_TOKEN     = 8'hFE;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_R1    = 2'd1;
  localparam logic [1:0] ST_BAD_TOKEN = 2'd2;

  // crc7, polynomial x^7 + x^3 + 1, one byte msb first
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] b);
    logic [6:0] c;
    logic       fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = c[6] ^ b[i];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ 7'h09;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/sd_spi_command_sequencer_unit.sv =====
// top level of the sd card spi command sequencer
// the result of an accepted item is held in the output register from the next cycle
// throughput: one item per cycle; a new item is taken in the cycle the waiting result leaves
// crc7 is folded in one byte per item as the command frame goes out
// reset (rst, synchronous): idle, chip select released, card not ready,
// output register empty
module sd_spi_command_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // action[1:0], rx_byte[9:2], address[41:10], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // tx_byte[7:0], tx_valid[8], chip_select[9],
                                     // busy_res[10], done_res[11], status[13:12],
                                     // card_ready[14], zero
);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_CLOCKS    = 3'd1;
  localparam logic [2:0] PH_SEND      = 3'd2;
  localparam logic [2:0] PH_RESP_WAIT = 3'd3;
  localparam logic [2:0] PH_RESP_MORE = 3'd4;
  localparam logic [2:0] PH_TRAIL     = 3'd5;
  localparam logic [2:0] PH_TOKEN     = 3'd6;
  localparam logic [2:0] PH_BUSY      = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [39:0] frame_bytes, frame_bytes_next;
  logic [6:0]  crc_accumulator, crc_accumulator_next;
  logic [39:0] response_bytes, response_bytes_next;
  logic        ready_flag, ready_flag_next;
  logic        cs_level, cs_level_next;
  logic [5:0]  cmd_code, cmd_code_next;

  logic [1:0]  action;
  logic [7:0]  rx_byte;
  logic [31:0] address;
  logic        accept;

  logic        start;
  logic [5:0]  start_code;
  logic [31:0] start_arg;
  logic [7:0]  start_byte;
  logic [7:0]  r1;
  logic [5:0]  send_ofs;

  logic [7:0]  tx_byte;
  logic        tx_valid, done_res;
  logic [1:0]  status;
  logic        release_cs;

  assign action  = s_axis_tdata[1:0];
  assign rx_byte = s_axis_tdata[9:2];
  assign address = s_axis_tdata[41:10];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign r1         = response_bytes[7:0];
  assign start_byte = sdspi_pkg::CMD_START_BITS | {2'b00, start_code};
  assign send_ofs   = {3'd4 - byte_count[2:0], 3'b000};

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    response_bytes_next = response_bytes;
    ready_flag_next     = ready_flag;
    cs_level_next       = cs_level;
    start               = 1'b0;
    start_code          = sdspi_pkg::CMD_GO_IDLE;
    start_arg           = '0;
    tx_byte             = sdspi_pkg::BYTE_IDLE;
    tx_valid            = 1'b1;
    done_res            = 1'b0;
    status              = sdspi_pkg::ST_OK;
    release_cs          = 1'b0;
    frame_bytes_next     = frame_bytes;
    crc_accumulator_next = crc_accumulator;
    cmd_code_next        = cmd_code;

    case (phase)
      PH_IDLE: begin
        case (action)
          sdspi_pkg::ACT_EXCHANGE: begin
            tx_valid = 1'b0;
          end
          sdspi_pkg::ACT_INIT: begin
            ready_flag_next = 1'b0;
            cs_level_next   = 1'b0;
            byte_count_next = 4'd1;
            phase_next      = PH_CLOCKS;
          end
          sdspi_pkg::ACT_OPEN: begin
            start      = 1'b1;
            start_code = sdspi_pkg::CMD_READ_MULTI;
            start_arg  = address;
          end
          default: begin
            start      = 1'b1;
            start_code = sdspi_pkg::CMD_STOP_TRANS;
          end
        endcase
      end
      PH_CLOCKS: begin
        if (byte_count < sdspi_pkg::IDLE_CLOCK_BYTES) begin
          byte_count_next = byte_count + 4'd1;
        end else begin
          start      = 1'b1;
          start_code = sdspi_pkg::CMD_GO_IDLE;
        end
      end
      PH_SEND: begin
        if (byte_count < 4'd5) begin
          tx_byte              = frame_bytes[send_ofs +: 8];
          crc_accumulator_next = sdspi_pkg::crc7_byte(crc_accumulator, tx_byte);
          byte_count_next      = byte_count + 4'd1;
        end else if (byte_count == 4'd5) begin
          tx_byte         = {crc_accumulator, 1'b1};
          byte_count_next = 4'd6;
        end else begin
          phase_next = PH_RESP_WAIT;
        end
      end
      PH_RESP_WAIT: begin
        if (rx_byte != sdspi_pkg::BYTE_IDLE) begin
          response_bytes_next = {32'd0, rx_byte};
          if (cmd_code == sdspi_pkg::CMD_SEND_IF) begin
            byte_count_next = 4'd1;
            phase_next      = PH_RESP_MORE;
          end else begin
            phase_next = PH_TRAIL;
          end
        end
      end
      PH_RESP_MORE: begin
        response_bytes_next = {response_bytes[31:0], rx_byte};
        byte_count_next     = byte_count + 4'd1;
        if (byte_count_next >= 4'd5) begin
          phase_next = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        case (cmd_code)
          sdspi_pkg::CMD_GO_IDLE: begin
            start = 1'b1;
            if (r1 == sdspi_pkg::R1_IDLE_STATE) begin
              start_code = sdspi_pkg::CMD_SEND_IF;
              start_arg  = sdspi_pkg::ARG_IF_COND;
            end
          end
          sdspi_pkg::CMD_SEND_IF: begin
            start = 1'b1;
            if (response_bytes == sdspi_pkg::R7_EXPECTED) begin
              start_code = sdspi_pkg::CMD_APP_CMD;
            end else begin
              start_code = sdspi_pkg::CMD_SEND_IF;
              start_arg  = sdspi_pkg::ARG_IF_COND;
            end
          end
          sdspi_pkg::CMD_APP_CMD: begin
            start = 1'b1;
            if (r1 == sdspi_pkg::R1_IDLE_STATE) begin
              start_code = sdspi_pkg::CMD_SD_OP_COND;
              start_arg  = sdspi_pkg::ARG_HCS;
            end else begin
              start_code = sdspi_pkg::CMD_APP_CMD;
            end
          end
          sdspi_pkg::CMD_SD_OP_COND: begin
            if (r1 == sdspi_pkg::BYTE_ZERO) begin
              ready_flag_next = 1'b1;
              done_res        = 1'b1;
              release_cs      = 1'b1;
            end else begin
              start      = 1'b1;
              start_code = sdspi_pkg::CMD_APP_CMD;
            end
          end
          sdspi_pkg::CMD_READ_MULTI: begin
            if (r1 != sdspi_pkg::BYTE_ZERO) begin
              done_res   = 1'b1;
              status     = sdspi_pkg::ST_BAD_R1;
              release_cs = 1'b1;
            end else begin
              phase_next = PH_TOKEN;
            end
          end
          default: begin
            if (r1 != sdspi_pkg::BYTE_ZERO) begin
              done_res   = 1'b1;
              status     = sdspi_pkg::ST_BAD_R1;
              release_cs = 1'b1;
            end else begin
              phase_next = PH_BUSY;
            end
          end
        endcase
      end
      PH_TOKEN: begin
        if (rx_byte == sdspi_pkg::DATA_TOKEN) begin
          done_res = 1'b1;
        end else if (rx_byte != sdspi_pkg::BYTE_IDLE) begin
          done_res   = 1'b1;
          status     = sdspi_pkg::ST_BAD_TOKEN;
          release_cs = 1'b1;
        end
      end
      default: begin
        if (rx_byte != sdspi_pkg::BYTE_ZERO) begin
          done_res   = 1'b1;
          release_cs = 1'b1;
        end
      end
    endcase

    // command frame start
    if (start) begin
      cmd_code_next        = start_code;
      frame_bytes_next     = {start_byte, start_arg};
      crc_accumulator_next = sdspi_pkg::crc7_byte(7'd0, start_byte);
      byte_count_next      = 4'd1;
      phase_next           = PH_SEND;
      cs_level_next        = 1'b1;
      tx_byte              = start_byte;
    end

    // completion
    if (done_res) begin
      phase_next = PH_IDLE;
      tx_valid   = 1'b0;
      tx_byte    = sdspi_pkg::BYTE_IDLE;
      if (release_cs) begin
        cs_level_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_count      <= '0;
      frame_bytes     <= '0;
      crc_accumulator <= '0;
      response_bytes  <= '0;
      ready_flag      <= 1'b0;
      cs_level        <= 1'b0;
      cmd_code        <= sdspi_pkg::CMD_GO_IDLE;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        byte_count      <= byte_count_next;
        frame_bytes     <= frame_bytes_next;
        crc_accumulator <= crc_accumulator_next;
        response_bytes  <= response_bytes_next;
        ready_flag      <= ready_flag_next;
        cs_level        <= cs_level_next;
        cmd_code        <= cmd_code_next;
        m_axis_tvalid   <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {1'b0, ready_flag_next, status, done_res,
                       (phase_next != PH_IDLE), cs_level_next, tx_valid, tx_byte};
    end
  end

endmodule

// ===== verif/sd_spi_seq_checker.sv =====
`timescale 1ns / 1ps
// checker for the sd spi command sequencer: tracks the command sequence and compares each result
module sd_spi_seq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // action[1:0], rx_byte[9:2], address[41:10], zero
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,  // tx_byte[7:0], tx_valid[8], chip_select[9],
                                     // busy_res[10], done_res[11], status[13:12],
                                     // card_ready[14], zero
  output int          fail_count,
  output int          outstanding
);

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_CLOCKS,
    SQ_FRAME,
    SQ_WAIT_R1,
    SQ_R7_TAIL,
    SQ_TRAIL,
    SQ_WAIT_TOKEN,
    SQ_WAIT_BUSY
  } seq_phase_t;

  typedef struct packed {
    logic       card_ready;
    logic [1:0] status;
    logic       done;
    logic       busy;
    logic       chip_select;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } seq_result_t;

  seq_phase_t  sq_phase;
  logic [3:0]  step_cnt;
  logic [47:0] frame;
  logic [39:0] resp;
  logic        card_rdy;
  logic        cs_on;
  logic [5:0]  cur_cmd;

  logic [7:0]  out_tx;
  logic        out_req;
  logic        out_done;
  logic [1:0]  out_st;

  seq_result_t expected_replies[$];
  int          results_seen;

  function automatic logic [6:0] frame_crc(input logic [39:0] msg);
    logic [6:0] r;
    logic       fb;
    r = '0;
    for (int k = 39; k >= 0; k--) begin
      fb = r[6] ^ msg[k];
      r  = {r[5:0], 1'b0} ^ {3'b000, fb, 2'b00, fb};
    end
    return r;
  endfunction

  task reset_sequencer();
    sq_phase = SQ_IDLE;
    step_cnt = '0;
    frame    = '0;
    resp     = '0;
    card_rdy = 1'b0;
    cs_on    = 1'b0;
    cur_cmd  = '0;
  endtask

  task start_frame(input logic [5:0] cmd, input logic [31:0] arg);
    logic [7:0] head;
    logic [6:0] crc;
    head     = sdspi_pkg::CMD_START_BITS | {2'b00, cmd};
    crc      = frame_crc({head, arg});
    cur_cmd  = cmd;
    frame    = {head, arg, crc, 1'b1};
    step_cnt = 4'd1;
    sq_phase = SQ_FRAME;
    cs_on    = 1'b1;
    out_tx   = head;
  endtask

  task wrap_up(input logic [1:0] st, input logic release_cs);
    sq_phase = SQ_IDLE;
    if (release_cs) begin
      cs_on = 1'b0;
    end
    out_tx   = sdspi_pkg::BYTE_IDLE;
    out_req  = 1'b0;
    out_done = 1'b1;
    out_st   = st;
  endtask

  task advance_sequencer(input logic [1:0] act, input logic [7:0] rx,
                         input logic [31:0] addr, output seq_result_t res);
    logic [7:0] r1;
    logic [5:0] ofs;
    out_tx   = sdspi_pkg::BYTE_IDLE;
    out_req  = 1'b0;
    out_done = 1'b0;
    out_st   = sdspi_pkg::ST_OK;
    r1       = resp[7:0];
    if (sq_phase == SQ_IDLE) begin
      case (act)
        sdspi_pkg::ACT_EXCHANGE: begin
        end
        sdspi_pkg::ACT_INIT: begin
          card_rdy = 1'b0;
          cs_on    = 1'b0;
          step_cnt = 4'd1;
          sq_phase = SQ_CLOCKS;
          out_req  = 1'b1;
        end
        sdspi_pkg::ACT_OPEN: begin
          start_frame(sdspi_pkg::CMD_READ_MULTI, addr);
          out_req = 1'b1;
        end
        default: begin
          start_frame(sdspi_pkg::CMD_STOP_TRANS, '0);
          out_req = 1'b1;
        end
      endcase
    end else begin
      out_req = 1'b1;
      case (sq_phase)
        SQ_CLOCKS: begin
          if (step_cnt < sdspi_pkg::IDLE_CLOCK_BYTES) begin
            step_cnt = step_cnt + 4'd1;
          end else begin
            start_frame(sdspi_pkg::CMD_GO_IDLE, '0);
          end
        end
        SQ_FRAME: begin
          if (step_cnt < 4'd6) begin
            ofs      = {3'd5 - step_cnt[2:0], 3'b000};
            out_tx   = frame[ofs +: 8];
            step_cnt = step_cnt + 4'd1;
          end else begin
            sq_phase = SQ_WAIT_R1;
          end
        end
        SQ_WAIT_R1: begin
          if (rx != sdspi_pkg::BYTE_IDLE) begin
            resp = {32'd0, rx};
            if (cur_cmd == sdspi_pkg::CMD_SEND_IF) begin
              step_cnt = 4'd1;
              sq_phase = SQ_R7_TAIL;
            end else begin
              sq_phase = SQ_TRAIL;
            end
          end
        end
        SQ_R7_TAIL: begin
          resp     = {resp[31:0], rx};
          step_cnt = step_cnt + 4'd1;
          if (step_cnt >= 4'd5) begin
            sq_phase = SQ_TRAIL;
          end
        end
        SQ_TRAIL: begin
          case (cur_cmd)
            sdspi_pkg::CMD_GO_IDLE: begin
              if (r1 == sdspi_pkg::R1_IDLE_STATE) begin
                start_frame(sdspi_pkg::CMD_SEND_IF, sdspi_pkg::ARG_IF_COND);
              end else begin
                start_frame(sdspi_pkg::CMD_GO_IDLE, '0);
              end
            end
            sdspi_pkg::CMD_SEND_IF: begin
              if (resp == sdspi_pkg::R7_EXPECTED) begin
                start_frame(sdspi_pkg::CMD_APP_CMD, '0);
              end else begin
                start_frame(sdspi_pkg::CMD_SEND_IF, sdspi_pkg::ARG_IF_COND);
              end
            end
            sdspi_pkg::CMD_APP_CMD: begin
              if (r1 == sdspi_pkg::R1_IDLE_STATE) begin
                start_frame(sdspi_pkg::CMD_SD_OP_COND, sdspi_pkg::ARG_HCS);
              end else begin
                start_frame(sdspi_pkg::CMD_APP_CMD, '0);
              end
            end
            sdspi_pkg::CMD_SD_OP_COND: begin
              if (r1 == sdspi_pkg::BYTE_ZERO) begin
                card_rdy = 1'b1;
                wrap_up(sdspi_pkg::ST_OK, 1'b1);
              end else begin
                start_frame(sdspi_pkg::CMD_APP_CMD, '0);
              end
            end
            sdspi_pkg::CMD_READ_MULTI: begin
              if (r1 != sdspi_pkg::BYTE_ZERO) begin
                wrap_up(sdspi_pkg::ST_BAD_R1, 1'b1);
              end else begin
                sq_phase = SQ_WAIT_TOKEN;
              end
            end
            default: begin
              if (r1 != sdspi_pkg::BYTE_ZERO) begin
                wrap_up(sdspi_pkg::ST_BAD_R1, 1'b1);
              end else begin
                sq_phase = SQ_WAIT_BUSY;
              end
            end
          endcase
        end
        SQ_WAIT_TOKEN: begin
          if (rx == sdspi_pkg::DATA_TOKEN) begin
            wrap_up(sdspi_pkg::ST_OK, 1'b0);
          end else if (rx != sdspi_pkg::BYTE_IDLE) begin
            wrap_up(sdspi_pkg::ST_BAD_TOKEN, 1'b1);
          end
        end
        default: begin
          if (rx != sdspi_pkg::BYTE_ZERO) begin
            wrap_up(sdspi_pkg::ST_OK, 1'b1);
          end
        end
      endcase
    end
    res.tx_byte     = out_tx;
    res.tx_valid    = out_req;
    res.chip_select = cs_on;
    res.busy        = (sq_phase != SQ_IDLE);
    res.done        = out_done;
    res.status      = out_st;
    res.card_ready  = card_rdy;
  endtask

  task flag_mismatch(input string what, input logic [15:0] got, input logic [15:0] exp);
    $display("checker: result %0d %s got %h expected %h", results_seen, what, got, exp);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    seq_result_t got;
    seq_result_t exp;
    seq_result_t nxt;
    if (rst) begin
      reset_sequencer();
      expected_replies.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[14:0];
        if (expected_replies.size() == 0) begin
          flag_mismatch("unexpected item", m_axis_tdata, '0);
        end else begin
          exp = expected_replies.pop_front();
          if (got.tx_byte !== exp.tx_byte)
            flag_mismatch("tx_byte", 16'(got.tx_byte), 16'(exp.tx_byte));
          if (got.tx_valid !== exp.tx_valid)
            flag_mismatch("tx_valid", 16'(got.tx_valid), 16'(exp.tx_valid));
          if (got.chip_select !== exp.chip_select)
            flag_mismatch("chip_select", 16'(got.chip_select), 16'(exp.chip_select));
          if (got.busy !== exp.busy)
            flag_mismatch("busy_res", 16'(got.busy), 16'(exp.busy));
          if (got.done !== exp.done)
            flag_mismatch("done_res", 16'(got.done), 16'(exp.done));
          if (got.status !== exp.status)
            flag_mismatch("status", 16'(got.status), 16'(exp.status));
          if (got.card_ready !== exp.card_ready)
            flag_mismatch("card_ready", 16'(got.card_ready), 16'(exp.card_ready));
        end
        if (m_axis_tdata[15] !== 1'b0) flag_mismatch("pad bit", 16'(m_axis_tdata[15]), '0);
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_sequencer(s_axis_tdata[1:0], s_axis_tdata[9:2], s_axis_tdata[41:10], nxt);
        expected_replies.push_back(nxt);
      end
    end
    outstanding = expected_replies.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// testbench top: plays the card side of the sd spi sequencer and gives the verdict
module tb;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // action[1:0], rx_byte[9:2], address[41:10], zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // tx_byte[7:0], tx_valid[8], chip_select[9], busy_res[10],
                               // done_res[11], status[13:12], card_ready[14], zero

  int fail_count;
  int outstanding;
  int items_sent;
  int gap_pct;
  int stall_left;
  bit quiet;

  sd_spi_command_sequencer_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sd_spi_seq_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // result side stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 11);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [7:0] rx,
                           input logic [31:0] addr, input bit counted);
    int n;
    if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      n = $urandom_range(1, 12);
      repeat (n) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, addr, rx, act};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    if (counted) items_sent++;
  endtask

  // while busy the action field is ignored, so it is scrambled now and then
  task automatic busy_rx(input logic [7:0] rx);
    logic [1:0] act;
    act = sdspi_pkg::ACT_EXCHANGE;
    if ($urandom_range(0, 4) == 0) act = 2'($urandom_range(0, 3));
    send_item(act, rx, $urandom, 1'b1);
  endtask

  function automatic logic [7:0] off_byte(input logic [7:0] avoid);
    logic [7:0] r;
    do r = 8'($urandom_range(0, 254)); while (r == avoid);
    return r;
  endfunction

  function automatic logic [39:0] broken_r7();
    logic [39:0] v;
    if ($urandom_range(0, 1) == 0) begin
      v = sdspi_pkg::R7_EXPECTED ^ (40'd1 << $urandom_range(0, 31));
    end else begin
      v[39:32] = 8'($urandom_range(0, 254));
      v[31:0]  = $urandom;
      if (v == sdspi_pkg::R7_EXPECTED) v[0] = ~v[0];
    end
    return v;
  endfunction

  function automatic logic [31:0] pick_address();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic frame_body();
    repeat (6) busy_rx(8'($urandom));
  endtask

  task automatic answer_r1(input logic [7:0] r1);
    repeat ($urandom_range(0, 3)) busy_rx(sdspi_pkg::BYTE_IDLE);
    busy_rx(r1);
    busy_rx(8'($urandom));
  endtask

  task automatic answer_r7(input logic [39:0] v);
    repeat ($urandom_range(0, 3)) busy_rx(sdspi_pkg::BYTE_IDLE);
    for (int k = 4; k >= 0; k--) busy_rx(v[8 * k +: 8]);
    busy_rx(8'($urandom));
  endtask

  task automatic run_init();
    bit ok;
    send_item(sdspi_pkg::ACT_INIT, 8'($urandom), $urandom, 1'b1);
    repeat (10) busy_rx(8'($urandom));
    do begin
      frame_body();
      ok = ($urandom_range(0, 3) != 0);
      answer_r1(ok ? sdspi_pkg::R1_IDLE_STATE : off_byte(sdspi_pkg::R1_IDLE_STATE));
    end while (!ok);
    do begin
      frame_body();
      ok = ($urandom_range(0, 3) != 0);
      answer_r7(ok ? sdspi_pkg::R7_EXPECTED : broken_r7());
    end while (!ok);
    ok = 1'b0;
    while (!ok) begin
      frame_body();
      if ($urandom_range(0, 4) == 0) begin
        answer_r1(off_byte(sdspi_pkg::R1_IDLE_STATE));
      end else begin
        answer_r1(sdspi_pkg::R1_IDLE_STATE);
        frame_body();
        if ($urandom_range(0, 2) == 0) begin
          answer_r1(sdspi_pkg::BYTE_ZERO);
          ok = 1'b1;
        end else begin
          answer_r1($urandom_range(0, 1) ? sdspi_pkg::R1_IDLE_STATE
                                         : off_byte(sdspi_pkg::BYTE_ZERO));
        end
      end
    end
  endtask

  task automatic run_open(input logic [31:0] addr);
    send_item(sdspi_pkg::ACT_OPEN, 8'($urandom), addr, 1'b1);
    frame_body();
    if ($urandom_range(0, 5) == 0) begin
      answer_r1(off_byte(sdspi_pkg::BYTE_ZERO));
    end else begin
      answer_r1(sdspi_pkg::BYTE_ZERO);
      repeat ($urandom_range(0, 4)) busy_rx(sdspi_pkg::BYTE_IDLE);
      busy_rx(($urandom_range(0, 4) == 0) ? off_byte(sdspi_pkg::DATA_TOKEN)
                                          : sdspi_pkg::DATA_TOKEN);
    end
  endtask

  task automatic run_close();
    send_item(sdspi_pkg::ACT_CLOSE, 8'($urandom), $urandom, 1'b1);
    frame_body();
    if ($urandom_range(0, 5) == 0) begin
      answer_r1(off_byte(sdspi_pkg::BYTE_ZERO));
    end else begin
      answer_r1(sdspi_pkg::BYTE_ZERO);
      repeat ($urandom_range(0, 5)) busy_rx(sdspi_pkg::BYTE_ZERO);
      busy_rx(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic idle_noise();
    repeat ($urandom_range(1, 3))
      send_item(sdspi_pkg::ACT_EXCHANGE, 8'($urandom), $urandom, 1'b0);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    items_sent    = 0;
    gap_pct       = 20;
    stall_left    = 0;
    quiet         = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: idle exchanges, failing open at top address, close with busy wait
    send_item(sdspi_pkg::ACT_EXCHANGE, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    send_item(sdspi_pkg::ACT_EXCHANGE, 8'h00, 32'h0000_0000, 1'b0);
    send_item(sdspi_pkg::ACT_OPEN, 8'h00, 32'hFFFF_FFFF, 1'b1);
    frame_body();
    answer_r1(8'h80);
    send_item(sdspi_pkg::ACT_CLOSE, 8'hFF, 32'h0000_0000, 1'b1);
    frame_body();
    answer_r1(sdspi_pkg::BYTE_ZERO);
    busy_rx(sdspi_pkg::BYTE_ZERO);
    busy_rx(sdspi_pkg::BYTE_IDLE);

    run_init();
    while (items_sent < 800) begin
      if (items_sent >= 700) quiet = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: gap_pct = 0;
          1: gap_pct = 5;
          2: gap_pct = 25;
          default: gap_pct = 60;
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1: run_init();
        2, 3, 4, 5: run_open(pick_address());
        6, 7, 8: run_close();
        default: idle_noise();
      endcase
    end
    repeat (20) send_item(2'($urandom_range(0, 3)), 8'($urandom), $urandom, 1'b1);

    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
